// ===== rtl/hdp_pkg.sv =====
// Shared types, constants and helpers for the pruned Hellinger distance block.
// Used by hdp_sqrt and hellinger_distance_pruned; depends on nothing else.

package hdp_pkg;

   localparam int CFG_W = 13;
   localparam int IN_W = 16;
   localparam int THR_W = 22;
   localparam int DIST_W = 23;
   localparam int SUM_W = 44;
   localparam int FRAC_SHIFT = 16;
   localparam int GROUP_BITS = 2;
   localparam int FIN_IT = SUM_W / 2;
   localparam int MAX_DIMENSIONS = 4096;
   localparam int DIM_RESET = 4;
   localparam int ELEMENT_BITS_DEFAULT = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT,
      ST_DIFF,
      ST_SQUARE,
      ST_ACCUM,
      ST_TEST,
      ST_FINAL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } sqrt_ctl_type;

   // Zero acts as one element, and counts above the limit saturate.
   function automatic logic [CFG_W-1:0] eff_dims(input logic [CFG_W-1:0] value);
      logic [CFG_W-1:0] d;
      d = value;
      if (d == '0) begin
         d = CFG_W'(1);
      end
      if (int'(d) > MAX_DIMENSIONS) begin
         d = CFG_W'(MAX_DIMENSIONS);
      end
      return d;
   endfunction

endpackage

// ===== rtl/hellinger_distance_pruned.sv =====
// Top level of the pruned Hellinger distance block: control, accumulator and output register.
// Depends on hdp_pkg and two hdp_sqrt root units.

// Each item carries one element pair; the block takes square roots of both elements in
// Q8.8 with two root units side by side, adds the squared difference to a Q28.16 sum,
// and after every full group of four elements compares the sum with twice the squared
// threshold. An item is accepted, then goes through the root iterations, one per two
// radicand bits (set by the root units), then difference, square, accumulate and test.
// Once a vector is pruned each further item goes from acceptance straight to the test.
// The last item of a vector adds a root of half the sum in the left unit, skipped if the
// vector was pruned, and then loads the output register, waiting while an earlier
// result is still stalled there.
// A result waits in the output register while the next vector's items are accepted.

module hellinger_distance_pruned #(
   parameter int ELEMENT_BITS = hdp_pkg::ELEMENT_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [hdp_pkg::IN_W-1:0]    req_left_value,
   input  logic [hdp_pkg::IN_W-1:0]    req_right_value,
   input  logic [hdp_pkg::THR_W-1:0]   req_prune_threshold,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [hdp_pkg::DIST_W-1:0]  rsp_distance,
   output logic                        rsp_pruned,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [hdp_pkg::CFG_W-1:0]   csr_dimension_count
);

   localparam int OPW = ELEMENT_BITS < hdp_pkg::IN_W ? ELEMENT_BITS : hdp_pkg::IN_W;
   localparam int E_IT = (OPW + hdp_pkg::FRAC_SHIFT + 1) / 2;
   localparam int ER_W = 2 * E_IT;
   localparam int RT_W = E_IT > hdp_pkg::FIN_IT ? E_IT : hdp_pkg::FIN_IT;
   localparam int RAD_W = 2 * RT_W;
   localparam int MOP = E_IT > hdp_pkg::THR_W ? E_IT : hdp_pkg::THR_W;
   localparam int PROD_W = 2 * MOP;
   localparam int CMP_W = hdp_pkg::SUM_W > PROD_W + 1 ? hdp_pkg::SUM_W : PROD_W + 1;
   localparam int CNT_W = $clog2(RT_W);
   localparam int SUM_W = hdp_pkg::SUM_W;
   localparam int CFG_W = hdp_pkg::CFG_W;

   hdp_pkg::state_type state_ff, state_in;
   logic [CFG_W-1:0]          dims_ff, dims_in;
   logic [CFG_W-1:0]          idx_ff, idx_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic                      pruned_ff, pruned_in;
   logic [hdp_pkg::THR_W-1:0] thr_ff, thr_in;
   logic [E_IT-1:0]           diff_ff, diff_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [hdp_pkg::DIST_W-1:0] rsp_distance_ff, rsp_distance_in;
   logic                      rsp_pruned_ff, rsp_pruned_in;

   hdp_pkg::sqrt_ctl_type l_ctl, r_ctl;
   logic [RAD_W-1:0] l_rad, r_rad;
   logic [RT_W-1:0]  l_root, r_root;
   logic [ER_W-1:0]  l_elem, r_elem;
   logic             req_take, csr_take, emit_go;
   logic [CFG_W-1:0] pos;
   logic             fire, last, pruned_next, start_final;
   logic [MOP-1:0]   mul_op;
   logic [PROD_W-1:0] mul_p;
   logic [SUM_W:0]   sum_wide;

   hdp_sqrt #(.RT_W(RT_W)) u_sqrt_left (
      .clock    (clock),
      .ctl      (l_ctl),
      .radicand (l_rad),
      .root     (l_root)
   );

   hdp_sqrt #(.RT_W(RT_W)) u_sqrt_right (
      .clock    (clock),
      .ctl      (r_ctl),
      .radicand (r_rad),
      .root     (r_root)
   );

   assign req_take = req_valid && !req_stall;
   assign csr_take = csr_valid && csr_ready;
   assign emit_go = (state_ff == hdp_pkg::ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign pos = idx_ff + CFG_W'(1);
   assign last = pos >= dims_ff;
   assign fire = !pruned_ff && (pos[hdp_pkg::GROUP_BITS-1:0] == '0) && (pos <= dims_ff)
                 && (CMP_W'(sum_ff) > CMP_W'({prod_ff, 1'b0}));
   assign pruned_next = pruned_ff || fire;
   assign start_final = (state_ff == hdp_pkg::ST_TEST) && last && !pruned_next;

   assign l_elem = ER_W'({req_left_value[OPW-1:0], hdp_pkg::FRAC_SHIFT'(0)});
   assign r_elem = ER_W'({req_right_value[OPW-1:0], hdp_pkg::FRAC_SHIFT'(0)});
   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(prod_ff);
   assign mul_p = PROD_W'(mul_op) * PROD_W'(mul_op);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hdp_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = pruned_ff ? hdp_pkg::ST_TEST : hdp_pkg::ST_ROOT;
            end
         end
         hdp_pkg::ST_ROOT: begin
            if (cnt_ff == '0) begin
               state_in = hdp_pkg::ST_DIFF;
            end
         end
         hdp_pkg::ST_DIFF: state_in = hdp_pkg::ST_SQUARE;
         hdp_pkg::ST_SQUARE: state_in = hdp_pkg::ST_ACCUM;
         hdp_pkg::ST_ACCUM: state_in = hdp_pkg::ST_TEST;
         hdp_pkg::ST_TEST: begin
            if (!last) begin
               state_in = hdp_pkg::ST_IDLE;
            end else if (pruned_next) begin
               state_in = hdp_pkg::ST_EMIT;
            end else begin
               state_in = hdp_pkg::ST_FINAL;
            end
         end
         hdp_pkg::ST_FINAL: begin
            if (cnt_ff == '0) begin
               state_in = hdp_pkg::ST_EMIT;
            end
         end
         hdp_pkg::ST_EMIT: begin
            if (emit_go) begin
               state_in = hdp_pkg::ST_IDLE;
            end
         end
         default: state_in = hdp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != hdp_pkg::ST_IDLE) || csr_valid;
      csr_ready = state_ff == hdp_pkg::ST_IDLE;
      r_ctl.load = req_take && !pruned_ff;
      r_ctl.step = state_ff == hdp_pkg::ST_ROOT;
      l_ctl.load = (req_take && !pruned_ff) || start_final;
      l_ctl.step = (state_ff == hdp_pkg::ST_ROOT) || (state_ff == hdp_pkg::ST_FINAL);
      r_rad = RAD_W'(r_elem) << (RAD_W - ER_W);
      if (state_ff == hdp_pkg::ST_IDLE) begin
         l_rad = RAD_W'(l_elem) << (RAD_W - ER_W);
      end else begin
         l_rad = RAD_W'({1'b0, sum_ff[SUM_W-1:1]}) << (RAD_W - SUM_W);
      end
      if (state_ff == hdp_pkg::ST_ACCUM) begin
         mul_op = MOP'(thr_ff);
      end else begin
         mul_op = MOP'(diff_ff);
      end
   end

   always_comb begin
      dims_in = dims_ff;
      idx_in = idx_ff;
      sum_in = sum_ff;
      pruned_in = pruned_ff;
      thr_in = thr_ff;
      diff_in = diff_ff;
      prod_in = prod_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_distance_in = rsp_distance_ff;
      rsp_pruned_in = rsp_pruned_ff;
      if (csr_take) begin
         dims_in = hdp_pkg::eff_dims(csr_dimension_count);
         idx_in = '0;
         sum_in = '0;
         pruned_in = 1'b0;
      end
      if (req_take) begin
         cnt_in = CNT_W'(E_IT - 1);
         if (idx_ff == '0) begin
            thr_in = req_prune_threshold;
         end
      end
      if ((state_ff == hdp_pkg::ST_ROOT) || (state_ff == hdp_pkg::ST_FINAL)) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (state_ff == hdp_pkg::ST_DIFF) begin
         diff_in = (l_root[E_IT-1:0] >= r_root[E_IT-1:0]) ?
                   l_root[E_IT-1:0] - r_root[E_IT-1:0] :
                   r_root[E_IT-1:0] - l_root[E_IT-1:0];
      end
      if ((state_ff == hdp_pkg::ST_SQUARE) || (state_ff == hdp_pkg::ST_ACCUM)) begin
         prod_in = mul_p;
      end
      if (state_ff == hdp_pkg::ST_ACCUM) begin
         sum_in = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      end
      if (state_ff == hdp_pkg::ST_TEST) begin
         pruned_in = pruned_next;
         if (!last) begin
            idx_in = pos;
         end
      end
      if (start_final) begin
         cnt_in = CNT_W'(hdp_pkg::FIN_IT - 1);
      end
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         rsp_pruned_in = pruned_ff;
         rsp_distance_in = pruned_ff ? {thr_ff, 1'b0} : hdp_pkg::DIST_W'(l_root);
         idx_in = '0;
         sum_in = '0;
         pruned_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hdp_pkg::ST_IDLE;
         dims_ff <= hdp_pkg::eff_dims(CFG_W'(hdp_pkg::DIM_RESET));
         idx_ff <= '0;
         sum_ff <= '0;
         pruned_ff <= 1'b0;
         thr_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dims_ff <= dims_in;
         idx_ff <= idx_in;
         sum_ff <= sum_in;
         pruned_ff <= pruned_in;
         thr_ff <= thr_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      rsp_distance_ff <= rsp_distance_in;
      rsp_pruned_ff <= rsp_pruned_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_pruned = rsp_pruned_ff;

`ifndef SYNTHESIS
   a_index_in_vector: assert property (@(posedge clock) disable iff (reset)
      idx_ff < dims_ff)
      else $error("element index reached the vector length");

   a_emit_fills_output: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> rsp_valid_ff)
      else $error("result load did not fill the output register");

   a_sum_frozen_when_pruned: assert property (@(posedge clock) disable iff (reset)
      (pruned_ff && !emit_go && !csr_take) |=> $stable(sum_ff))
      else $error("sum changed after the vector was pruned");

   a_root_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hdp_pkg::ST_ROOT) |-> (int'(cnt_ff) < E_IT))
      else $error("root iteration count out of range");
`endif

endmodule

// ===== rtl/hdp_sqrt.sv =====
// Digit-serial integer square root, two radicand bits per step.
// Depends on hdp_pkg for the control struct.

module hdp_sqrt #(
   parameter int RT_W = hdp_pkg::FIN_IT
) (
   input  logic                 clock,
   input  hdp_pkg::sqrt_ctl_type ctl,
   input  logic [2*RT_W-1:0]    radicand,
   output logic [RT_W-1:0]      root
);

   localparam int RAD_W = 2 * RT_W;
   localparam int REM_W = RT_W + 2;

   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [RT_W-1:0]  root_ff, root_in;
   logic [REM_W-1:0] rem_shift;
   logic [REM_W-1:0] trial;
   logic             fit;

   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial = {root_ff, 2'b01};
   assign fit = rem_shift >= trial;

   always_comb begin
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      if (ctl.load) begin
         rad_in = radicand;
         rem_in = '0;
         root_in = '0;
      end else if (ctl.step) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         rem_in = fit ? rem_shift - trial : rem_shift;
         root_in = {root_ff[RT_W-2:0], fit};
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;

endmodule
